/* hdl/mru_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mru_pkg
// Shared types and constants for the most-recently-used handle list.
// ---------------------------------------------------------------------------
package mru_pkg;

  localparam int DEPTH    = 64;
  localparam int HANDLE_W = 32;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_TOUCH = 2'd0,
    KIND_DROP  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_DUMP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic                 eligible;
  } mru_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  out_handle;
    logic                 found;
    logic                 last_item;
  } mru_out_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [HANDLE_W-1:0]  key;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_INS,
    ST_DEL,
    ST_QSCAN,
    ST_DUMP,
    ST_EMIT
  } mru_state_t;

endpackage

/* hdl/mru_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mru_cell
// One list slot: holds a handle, compares it against the broadcast key and
// trades its handle with the neighbor slots on insert, delete and rotate.
// ---------------------------------------------------------------------------
module mru_cell
  import mru_pkg::*;
(
  input  logic                clk,
  input  cell_cmd_t           cmd,
  input  logic                occupied,
  input  logic                prior_hit,
  input  logic                is_tail,
  input  logic [HANDLE_W-1:0] prev_entry,
  input  logic [HANDLE_W-1:0] next_entry,
  input  logic [HANDLE_W-1:0] front_entry,
  output logic [HANDLE_W-1:0] entry,
  output logic                hit
);

  logic [HANDLE_W-1:0] entry_r, entry_nxt;
  logic                hit_r, hit_nxt;

  // Select the next slot content from the broadcast operation
  always_comb begin
    entry_nxt = entry_r;
    hit_nxt   = hit_r;
    case (cmd.op)
      CELL_CMP: begin
        hit_nxt = occupied && (entry_r == cmd.key);
      end
      CELL_INS: begin
        // shift toward the back up to and including the old copy
        if (!prior_hit) begin
          entry_nxt = prev_entry;
        end
      end
      CELL_DEL: begin
        // close the gap from the matching slot onward
        if (prior_hit || hit_r) begin
          entry_nxt = next_entry;
        end
      end
      CELL_ROT: begin
        entry_nxt = is_tail ? front_entry : next_entry;
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

/* hdl/mru_handle_list.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mru_handle_list
// Move-to-front list of up to DEPTH nonzero handles built as a chain of cells.
// ---------------------------------------------------------------------------
// Touch and drop requests first compare the key in every cell, then shift
// the chain. Query and dump requests rotate the whole chain one slot per
// cycle through the front cell; a dump rotation pauses while the result side
// stalls, and an empty list skips the rotation. One request is in flight at a
// time; in_stall stays high until it is done. The rotation leaves the list as
// it was.
// ---------------------------------------------------------------------------
module mru_handle_list
  import mru_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mru_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mru_out_t out_data
);

  mru_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    rot_r, rot_nxt;
  logic [HANDLE_W-1:0] key_r, key_nxt;
  kind_t               kind_r, kind_nxt;
  logic                qfound_r, qfound_nxt;
  logic [HANDLE_W-1:0] qres_r, qres_nxt;
  logic                out_valid_r, out_valid_nxt;
  mru_out_t            out_r, out_nxt;

  cell_cmd_t           cmd;
  logic [HANDLE_W-1:0] entry_q [DEPTH];
  logic [DEPTH-1:0]    hit_vec;
  logic [DEPTH-1:0]    prior_vec;
  logic                any_hit;
  logic                slot_free;
  logic                accept;
  logic                last_rot;
  logic [HANDLE_W-1:0] front;

  function automatic logic [DEPTH-1:0] low_mask(input int n);
    logic [DEPTH-1:0] m;
    m = '0;
    for (int j = 0; j < DEPTH; j++) begin
      m[j] = (j < n);
    end
    return m;
  endfunction

  assign front     = entry_q[0];
  assign any_hit   = |hit_vec;
  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign last_rot  = (rot_r == (count_r - CNT_W'(1)));

  // Flag cells that sit behind the matching cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prior_vec[i] = |(hit_vec & low_mask(i));
    end
  end

  // Build the chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [HANDLE_W-1:0] prev_e;
    logic [HANDLE_W-1:0] next_e;

    if (g == 0) begin : g_head
      assign prev_e = cmd.key;
    end else begin : g_body
      assign prev_e = entry_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_e = entry_q[g];
    end else begin : g_mid
      assign next_e = entry_q[g+1];
    end

    mru_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (CNT_W'(g) < count_r),
      .prior_hit   (prior_vec[g]),
      .is_tail     (count_r == CNT_W'(g + 1)),
      .prev_entry  (prev_e),
      .next_entry  (next_e),
      .front_entry (front),
      .entry       (entry_q[g]),
      .hit         (hit_vec[g])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_TOUCH: begin
              if (in_data.eligible && (in_data.handle != '0)) begin
                state_nxt = ST_CMP;
              end
            end
            KIND_DROP: begin
              if (in_data.handle != '0) begin
                state_nxt = ST_CMP;
              end
            end
            KIND_QUERY: begin
              state_nxt = (count_r == '0) ? ST_EMIT : ST_QSCAN;
            end
            KIND_DUMP: begin
              state_nxt = (count_r == '0) ? ST_EMIT : ST_DUMP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CMP: begin
        state_nxt = (kind_r == KIND_TOUCH) ? ST_INS : ST_DEL;
      end
      ST_INS, ST_DEL: begin
        state_nxt = ST_IDLE;
      end
      ST_QSCAN: begin
        if (last_rot) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DUMP: begin
        if (slot_free && last_rot) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath control and result loading
  always_comb begin
    cmd.op        = CELL_HOLD;
    cmd.key       = key_r;
    count_nxt     = count_r;
    rot_nxt       = rot_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    qfound_nxt    = qfound_r;
    qres_nxt      = qres_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt    = in_data.handle;
          kind_nxt   = in_data.kind;
          rot_nxt    = '0;
          qfound_nxt = 1'b0;
        end
      end
      ST_CMP: begin
        cmd.op = CELL_CMP;
      end
      ST_INS: begin
        cmd.op = CELL_INS;
        if (!any_hit && (count_r != CNT_W'(DEPTH))) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_DEL: begin
        cmd.op = CELL_DEL;
        if (any_hit) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ST_QSCAN: begin
        cmd.op  = CELL_ROT;
        rot_nxt = rot_r + CNT_W'(1);
        if (!qfound_r && (front != key_r)) begin
          qfound_nxt = 1'b1;
          qres_nxt   = front;
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd.op            = CELL_ROT;
          rot_nxt           = rot_r + CNT_W'(1);
          out_valid_nxt     = 1'b1;
          out_nxt.out_handle = front;
          out_nxt.found     = 1'b1;
          out_nxt.last_item = last_rot;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.out_handle = qfound_r ? qres_r : '0;
          out_nxt.found      = qfound_r;
          out_nxt.last_item  = 1'b1;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rot_r    <= rot_nxt;
    key_r    <= key_nxt;
    kind_r   <= kind_nxt;
    qfound_r <= qfound_nxt;
    qres_r   <= qres_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/mru_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mru_checker
// Port-level checks for the handle list, bound to the top level.
// ---------------------------------------------------------------------------
module mru_checker
  import mru_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input mru_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input mru_out_t out_data
);

  // A query or dump request always occupies the block for a while
  a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     ((in_data.kind == KIND_QUERY) || (in_data.kind == KIND_DUMP)))
    |=> in_stall)
    else $error("block took a new request right after a query or dump");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A result without an entry ends its request
  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.last_item && (out_data.out_handle == '0)))
    else $error("empty result not marked last");

  // Listed entries are never the null handle
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> (out_data.out_handle != '0))
    else $error("zero handle reported as found");

endmodule

bind mru_handle_list mru_checker u_mru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
